// File: rtl/core/stpra_pkg.sv
// Shared types and constants of the progression range-add unit.
// Used by stpra_ram, stpra_ctrl and the top level; depends on nothing.
`default_nettype none

package stpra_pkg;

  // Width that holds any position count up to the largest supported size.
  localparam int unsigned PosW = 17;
  // Width of one stored value and of the data fields.
  localparam int unsigned DataW = 64;

  // Command codes.
  typedef enum logic [0:0] {
    CmdAdd   = 1'b0,
    CmdQuery = 1'b1
  } cmd_e;

  typedef logic [DataW-1:0] data_t;
  typedef logic [PosW-1:0] pos_t;

endpackage

`default_nettype wire

// File: rtl/core/segment_tree_progression_range_add_unit.sv
// Top level of the progression range-add unit.
// Depends on stpra_pkg, stpra_ram and stpra_ctrl.
`default_nettype none

// Holds SIZE signed 64-bit values, zero after reset, in one memory with one
// entry per position. An update adds start + step*(i-low) to every position i
// of [low, high) (high clipped to SIZE, empty ranges ignored) and returns no
// beat; a query returns one beat with the value at its position, or zero for a
// position at or beyond SIZE. Timing: after reset a clearing pass writes zero
// to every entry, during which no item is taken. An update holds the input
// while it walks each position of the clipped range after acceptance (an
// empty range is taken without holding the input at all), since each position
// is a read-modify-write through the single memory write port. A query holds
// the input while it is in the query state, which lasts longer while an earlier
// result beat is still stalled, and its result beat is registered from the
// query state once the output is free. All sums wrap modulo 2^64.
module segment_tree_progression_range_add_unit
  import stpra_pkg::*;
#(
  parameter int unsigned SIZE = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cmd_i,
  input  wire logic [9:0]  range_low_i,
  input  wire logic [10:0] range_high_i,
  input  wire logic [63:0] start_value_i,
  input  wire logic [63:0] step_value_i,
  input  wire logic [9:0]  query_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      point_value_o
);

  localparam int unsigned AddrW = (SIZE > 1) ? $clog2(SIZE) : 1;

  logic             we;
  logic [AddrW-1:0] waddr;
  data_t            wdata;
  logic             re;
  logic [AddrW-1:0] raddr;
  data_t            rdata;

  // Sequencer.
  stpra_ctrl #(
    .Size  (SIZE),
    .AddrW (AddrW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .range_low_i   (range_low_i),
    .range_high_i  (range_high_i),
    .start_value_i (start_value_i),
    .step_value_i  (step_value_i),
    .query_index_i (query_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .point_value_o (point_value_o),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .re_o          (re),
    .raddr_o       (raddr),
    .rdata_i       (rdata)
  );

  // Value memory.
  stpra_ram #(
    .Depth (SIZE),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/stpra_ram.sv
// Single-port-write, single-port-read value memory with registered read data.
// Depends on stpra_pkg for the data type.
`default_nettype none

module stpra_ram
  import stpra_pkg::*;
#(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire data_t            wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output data_t                 rdata_o
);

  data_t mem_q [Depth];
  data_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/stpra_ctrl.sv
// Sequencer of the progression range-add unit: clearing pass, per-position
// read-modify-write of updates, query reads and the result register.
// Depends on stpra_pkg.
`default_nettype none

module stpra_ctrl
  import stpra_pkg::*;
#(
  parameter int unsigned Size  = 1024,
  parameter int unsigned AddrW = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             cmd_i,
  input  wire logic [9:0]       range_low_i,
  input  wire logic [10:0]      range_high_i,
  input  wire data_t            start_value_i,
  input  wire data_t            step_value_i,
  input  wire logic [9:0]       query_index_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output data_t                 point_value_o,
  output logic                  we_o,
  output logic [AddrW-1:0]      waddr_o,
  output data_t                 wdata_o,
  output logic                  re_o,
  output logic [AddrW-1:0]      raddr_o,
  input  wire data_t            rdata_i
);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StUpdate,
    StQuery
  } state_e;

  localparam pos_t SizeP = PosW'(Size);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Size - 1);

  state_e           state_q, state_d;
  logic [AddrW-1:0] cur_q, cur_d;
  logic [AddrW-1:0] last_q, last_d;
  data_t            term_q, term_d;
  data_t            step_q, step_d;
  logic             zero_q, zero_d;
  logic             out_valid_q, out_valid_d;
  data_t            out_value_q, out_value_d;

  logic in_accept;
  logic out_free;
  pos_t low_p, high_p, high_clip, query_p;

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !(out_valid_q && out_stall_i);

  // Range clipping against the array size.
  assign low_p     = PosW'(range_low_i);
  assign high_p    = PosW'(range_high_i);
  assign high_clip = (high_p > SizeP) ? SizeP : high_p;
  assign query_p   = PosW'(query_index_i);

  // Next-state and memory access logic.
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    last_d      = last_q;
    term_d      = term_q;
    step_d      = step_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    we_o        = 1'b0;
    waddr_o     = cur_q;
    wdata_o     = rdata_i + term_q;
    re_o        = 1'b0;
    raddr_o     = cur_q;
    unique case (state_q)
      StClear: begin
        we_o    = 1'b1;
        wdata_o = '0;
        cur_d   = cur_q + 1'b1;
        if (cur_q == LastAddr) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_accept) begin
          if (cmd_i == CmdQuery) begin
            zero_d  = (query_p >= SizeP);
            re_o    = 1'b1;
            raddr_o = query_p[AddrW-1:0];
            state_d = StQuery;
          end else if (low_p < high_clip) begin
            re_o    = 1'b1;
            raddr_o = low_p[AddrW-1:0];
            cur_d   = low_p[AddrW-1:0];
            last_d  = AddrW'(high_clip - 1'b1);
            term_d  = start_value_i;
            step_d  = step_value_i;
            state_d = StUpdate;
          end
        end
      end
      StUpdate: begin
        // Read data belongs to cur_q; the next position is read meanwhile.
        we_o = 1'b1;
        if (cur_q == last_q) begin
          state_d = StIdle;
        end else begin
          re_o    = 1'b1;
          raddr_o = cur_q + 1'b1;
          cur_d   = cur_q + 1'b1;
          term_d  = term_q + step_q;
        end
      end
      StQuery: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = zero_q ? '0 : rdata_i;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    last_q      <= last_d;
    term_q      <= term_d;
    step_q      <= step_d;
    zero_q      <= zero_d;
    out_value_q <= out_value_d;
  end

  assign out_valid_o   = out_valid_q;
  assign point_value_o = out_value_q;

  // A read never targets the entry being written in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (re_o && we_o) |-> (raddr_o != waddr_o))
    else $error("read and write of the same entry in one cycle");

  // Memory writes only during the clearing pass or an update.
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> (state_q == StClear || state_q == StUpdate))
    else $error("memory write outside clear or update");

  // A result is produced only from the query state.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StQuery))
    else $error("result raised outside a query");

  // An update walks upward and never passes its last position.
  a_update_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StUpdate && state_d == StUpdate) |-> (cur_q != last_q))
    else $error("update ran past its last position");

endmodule

`default_nettype wire
